/* sv/ctpt_pkg.sv */
// Shared constants, codes and types of the timed cover position tracker.
package ctpt_pkg;

  // Position is fixed point with FULL_SCALE_BITS fraction bits.
  localparam int unsigned FULL_SCALE_BITS = 24;
  localparam int unsigned POS_W = FULL_SCALE_BITS + 1;

  localparam logic [POS_W-1:0] FULL_POS = POS_W'(1) << FULL_SCALE_BITS;
  localparam logic [POS_W-1:0] HALF_POS = POS_W'(1) << (FULL_SCALE_BITS - 1);
  localparam logic [POS_W-1:0] ZERO_POS = '0;
  localparam logic [POS_W-1:0] RATE_RESET = POS_W'(1678);

  // Input operation codes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_STOP   = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_MOVE   = 2'd3;

  // Motion codes; motor command codes share the same encoding.
  localparam logic [1:0] MOTION_IDLE    = 2'd0;
  localparam logic [1:0] MOTION_OPENING = 2'd1;
  localparam logic [1:0] MOTION_CLOSING = 2'd2;

  localparam logic [1:0] CMD_STOP  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_OPEN_RATE  = 1'b0;
  localparam logic CFG_CLOSE_RATE = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] target_position;
    logic [1:0]       current_motion;
    logic [1:0]       last_direction;
  } track_state_t;

  typedef struct packed {
    logic             command_sent;
    logic [1:0]       command;
    logic [POS_W-1:0] position;
    logic [1:0]       motion;
  } track_result_t;

endpackage

/* sv/ctpt_ifs.sv */
// Handshake interfaces for the input, result and configuration channels.
interface ctpt_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [ctpt_pkg::POS_W-1:0] target;

  modport source (output valid, output op, output target, input ready);
  modport sink (input valid, input op, input target, output ready);
endinterface

interface ctpt_out_if;
  logic                      valid;
  logic                      ready;
  logic                      command_sent;
  logic [1:0]                command;
  logic [ctpt_pkg::POS_W-1:0] position;
  logic [1:0]                motion;

  modport source (output valid, output command_sent, output command, output position,
                  output motion, input ready);
  modport sink (input valid, input command_sent, input command, input position,
                input motion, output ready);
endinterface

interface ctpt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic                      index;
  logic [ctpt_pkg::POS_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/timed_cover_position_tracker.sv */
// Top level of the timed cover position tracker: input, state and result registers.
//
//   Channel   Direction  Payload                                   Interface
//   in_i      sink       op, target                                ctpt_in_if
//   out_o     source     command_sent, command, position, motion  ctpt_out_if
//   cfg_i     sink       index (0 open_rate, 1 close_rate), data   ctpt_cfg_if
//
// Every word waits in the input register after it is accepted until the result
// register is free or being emptied; then the step logic updates the
// state and loads the result register. One word is accepted in every cycle when the sink keeps
// ready high. A stalled result holds the input register and the state; the
// input channel stays ready while the input register is empty or moving on.
// Reset puts the cover half open, idle, with both rates at 1678 per tick.
module timed_cover_position_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  ctpt_in_if.sink       in_i,
  ctpt_out_if.source    out_o,
  ctpt_cfg_if.sink      cfg_i
);
  import ctpt_pkg::*;

  logic [POS_W-1:0] open_rate;
  logic [POS_W-1:0] close_rate;

  // Input register.
  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [POS_W-1:0] target_q;

  // Cover state.
  track_state_t     state_q;
  track_state_t     state_d;

  // Result register.
  logic             out_valid_q;
  track_result_t    result_q;
  track_result_t    result_d;

  logic             advance;

  ctpt_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .open_rate_o  (open_rate),
    .close_rate_o (close_rate)
  );

  ctpt_step u_step (
    .op_i         (op_q),
    .target_i     (target_q),
    .open_rate_i  (open_rate),
    .close_rate_i (close_rate),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // The word in the input register moves on whenever the result slot is free
  // or is being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q     <= in_i.op;
      target_q <= in_i.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.position        <= HALF_POS;
      state_q.target_position <= ZERO_POS;
      state_q.current_motion  <= MOTION_IDLE;
      state_q.last_direction  <= MOTION_IDLE;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.command_sent = result_q.command_sent;
  assign out_o.command      = result_q.command;
  assign out_o.position     = result_q.position;
  assign out_o.motion       = result_q.motion;

endmodule

/* sv/ctpt_cfg_regs.sv */
// Open and close rate registers written through the configuration channel.
module ctpt_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ctpt_cfg_if.sink                   cfg_i,
  output logic [ctpt_pkg::POS_W-1:0] open_rate_o,
  output logic [ctpt_pkg::POS_W-1:0] close_rate_o
);
  import ctpt_pkg::*;

  logic [POS_W-1:0] open_rate_q;
  logic [POS_W-1:0] close_rate_q;

  // The rate registers always accept a write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_rate_q  <= RATE_RESET;
      close_rate_q <= RATE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_OPEN_RATE:  open_rate_q  <= cfg_i.data;
        CFG_CLOSE_RATE: close_rate_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign open_rate_o  = open_rate_q;
  assign close_rate_o = close_rate_q;

endmodule

/* sv/ctpt_step.sv */
// Next-state and result logic for one word: tick, stop, toggle or move.
module ctpt_step (
  input  logic [1:0]                  op_i,
  input  logic [ctpt_pkg::POS_W-1:0]  target_i,
  input  logic [ctpt_pkg::POS_W-1:0]  open_rate_i,
  input  logic [ctpt_pkg::POS_W-1:0]  close_rate_i,
  input  ctpt_pkg::track_state_t      state_i,
  output ctpt_pkg::track_state_t      state_o,
  output ctpt_pkg::track_result_t     result_o
);
  import ctpt_pkg::*;

  logic [POS_W-1:0] req;
  logic [POS_W:0]   open_sum;
  logic [POS_W-1:0] tick_pos;
  logic             reached;
  logic             dir_en;
  logic [1:0]       dir;
  logic             issued;
  logic [1:0]       cmd;
  track_state_t     st;

  // Requests beyond fully open saturate.
  assign req = (target_i > FULL_POS) ? FULL_POS : target_i;
  assign open_sum = {1'b0, state_i.position} + {1'b0, open_rate_i};

  always_comb begin
    st       = state_i;
    dir_en   = 1'b0;
    dir      = MOTION_IDLE;
    issued   = 1'b0;
    cmd      = CMD_STOP;
    tick_pos = state_i.position;
    reached  = 1'b0;

    case (op_i)
      OP_TICK: begin
        if (state_i.current_motion == MOTION_OPENING) begin
          tick_pos = (open_sum > {1'b0, FULL_POS}) ? FULL_POS : open_sum[POS_W-1:0];
          reached  = tick_pos >= state_i.target_position;
        end else if (state_i.current_motion == MOTION_CLOSING) begin
          tick_pos = (close_rate_i >= state_i.position) ? ZERO_POS
                                                         : state_i.position - close_rate_i;
          reached  = tick_pos <= state_i.target_position;
        end
        st.position = tick_pos;
        if (reached) begin
          // At an end stop the motor stops by itself; elsewhere send a stop.
          if (state_i.target_position == FULL_POS || state_i.target_position == ZERO_POS) begin
            st.current_motion = MOTION_IDLE;
          end else begin
            dir_en = 1'b1;
            dir    = MOTION_IDLE;
          end
        end
      end
      OP_STOP: begin
        dir_en = 1'b1;
        dir    = MOTION_IDLE;
      end
      OP_TOGGLE: begin
        dir_en = 1'b1;
        if (state_i.current_motion != MOTION_IDLE) begin
          dir = MOTION_IDLE;
        end else if (state_i.position == ZERO_POS ||
                     state_i.last_direction == MOTION_CLOSING) begin
          st.target_position = FULL_POS;
          dir = MOTION_OPENING;
        end else begin
          st.target_position = ZERO_POS;
          dir = MOTION_CLOSING;
        end
      end
      OP_MOVE: begin
        if (req == state_i.position) begin
          // Repeat the end-stop direction so the motor gets the command again.
          if (req == FULL_POS || req == ZERO_POS) begin
            st.target_position = req;
            dir_en = 1'b1;
            dir    = (req == ZERO_POS) ? MOTION_CLOSING : MOTION_OPENING;
          end
        end else begin
          st.target_position = req;
          dir_en = 1'b1;
          dir    = (req < state_i.position) ? MOTION_CLOSING : MOTION_OPENING;
        end
      end
      default: ;
    endcase

    // A request for the direction already in progress sends nothing.
    if (dir_en && !(dir == state_i.current_motion && dir != MOTION_IDLE)) begin
      if (dir != MOTION_IDLE) begin
        st.last_direction = dir;
      end
      st.current_motion = dir;
      issued = 1'b1;
      cmd    = dir;
    end
  end

  assign state_o = st;

  assign result_o.command_sent = issued;
  assign result_o.command      = issued ? cmd : CMD_STOP;
  assign result_o.position     = st.position;
  assign result_o.motion       = st.current_motion;

endmodule

/* sv/ctpt_checker.sv */
// Port-level checks of the tracker's result channel, bound to the top level.
module ctpt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       command_sent_i,
  input logic [1:0]                 command_i,
  input logic [ctpt_pkg::POS_W-1:0] position_i,
  input logic [1:0]                 motion_i
);
  import ctpt_pkg::*;

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // No command means the command field reads as stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !command_sent_i |-> command_i == CMD_STOP)
    else $error("command field set without a command");

  // The estimated position never leaves the travel range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> position_i <= FULL_POS)
    else $error("position beyond fully open");

  // A command that is sent always matches the reported motion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && command_sent_i |-> command_i == motion_i)
    else $error("sent command disagrees with motion");

endmodule

bind timed_cover_position_tracker ctpt_checker u_ctpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .command_sent_i (out_o.command_sent),
  .command_i      (out_o.command),
  .position_i     (out_o.position),
  .motion_i       (out_o.motion)
);
